// File: design/sme_pkg.sv
// package for the stack machine execute block
// types, sizes, instruction codes and range helpers shared by all modules but sme_checker
// no dependencies
package sme_pkg;

  // sizes (program size is a power of two, code addresses wrap by masking)
  localparam int STACK_DEPTH  = 2048;
  localparam int PROGRAM_SIZE = 512;
  localparam int MAX_LEVELS   = 3;
  localparam int WORD_W       = 32;

  localparam int ADDR_W  = $clog2(STACK_DEPTH);
  localparam int PC_W    = $clog2(PROGRAM_SIZE);
  localparam int LV_W    = $clog2(MAX_LEVELS + 1);
  localparam int WIDE_W  = WORD_W + 2;
  localparam int OP_W    = 4;
  localparam int LEVEL_W = 2;
  localparam int FN_W    = 4;

  typedef logic [WORD_W-1:0]        word_t;
  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic [PC_W-1:0]          pc_t;
  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic [OP_W-1:0]          op_t;
  typedef logic [FN_W-1:0]          fn_t;

  localparam addr_t ADDR_MAX = addr_t'(STACK_DEPTH - 1);

  // opcodes
  localparam op_t OP_LIT   = 4'd1;
  localparam op_t OP_OPR   = 4'd2;
  localparam op_t OP_LOD   = 4'd3;
  localparam op_t OP_STO   = 4'd4;
  localparam op_t OP_CAL   = 4'd5;
  localparam op_t OP_INC   = 4'd6;
  localparam op_t OP_JMP   = 4'd7;
  localparam op_t OP_JPC   = 4'd8;
  localparam op_t OP_WRITE = 4'd9;
  localparam op_t OP_READ  = 4'd10;
  localparam op_t OP_HALT  = 4'd11;

  // opr function codes
  localparam fn_t FN_RET = 4'd0;
  localparam fn_t FN_NEG = 4'd1;
  localparam fn_t FN_ADD = 4'd2;
  localparam fn_t FN_SUB = 4'd3;
  localparam fn_t FN_MUL = 4'd4;
  localparam fn_t FN_DIV = 4'd5;
  localparam fn_t FN_ODD = 4'd6;
  localparam fn_t FN_MOD = 4'd7;
  localparam fn_t FN_EQ  = 4'd8;
  localparam fn_t FN_NE  = 4'd9;
  localparam fn_t FN_LT  = 4'd10;
  localparam fn_t FN_LE  = 4'd11;
  localparam fn_t FN_GT  = 4'd12;
  localparam fn_t FN_GE  = 4'd13;

  // one instruction request
  typedef struct packed {
    op_t                opcode_field;
    logic [LEVEL_W-1:0] level;
    word_t              operand;
    word_t              read_value;
  } instr_t;

  // one result
  typedef struct packed {
    pc_t   next_pc;
    word_t write_value;
    logic  write_valid;
    logic  halted;
    logic  fault;
  } res_t;

  // stack memory access
  typedef struct packed {
    logic  rd_en;
    addr_t rd_addr;
    logic  wr_en;
    addr_t wr_addr;
    word_t wr_data;
  } ram_req_t;

  // divider handshake
  typedef struct packed {
    logic  start;
    word_t dividend;
    word_t divisor;
  } div_req_t;

  typedef struct packed {
    logic  done;
    word_t quotient;
    word_t remainder;
  } div_rsp_t;

  function automatic wide_t ext_addr(addr_t a);
    return {{(WIDE_W - ADDR_W){1'b0}}, a};
  endfunction

  function automatic wide_t ext_word(word_t w);
    return {{(WIDE_W - WORD_W){w[WORD_W-1]}}, w};
  endfunction

  function automatic logic in_stack(wide_t i);
    return (i >= 0) && (i <= wide_t'(STACK_DEPTH - 1));
  endfunction

endpackage

// File: design/sme_ram.sv
// stack word memory, one write port and one registered read port
// depends on sme_pkg
module sme_ram (
  input  logic              clk,
  input  sme_pkg::ram_req_t req,
  output sme_pkg::word_t    rd_data
);

  sme_pkg::word_t mem [sme_pkg::STACK_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

// File: design/sme_alu.sv
// combinational opr operations: negate, add, subtract, multiply, odd, compares
// depends on sme_pkg; unary operations act on y
module sme_alu (
  input  sme_pkg::fn_t   fn,
  input  sme_pkg::word_t x,
  input  sme_pkg::word_t y,
  output sme_pkg::word_t r
);

  logic signed [sme_pkg::WORD_W-1:0] xs, ys;

  assign xs = $signed(x);
  assign ys = $signed(y);

  // operation select
  always_comb begin
    unique case (fn)
      sme_pkg::FN_NEG: r = sme_pkg::word_t'(0) - y;
      sme_pkg::FN_ADD: r = x + y;
      sme_pkg::FN_SUB: r = x - y;
      sme_pkg::FN_MUL: r = x * y;
      sme_pkg::FN_ODD: r = sme_pkg::word_t'(y[0]);
      sme_pkg::FN_EQ:  r = sme_pkg::word_t'(xs == ys);
      sme_pkg::FN_NE:  r = sme_pkg::word_t'(xs != ys);
      sme_pkg::FN_LT:  r = sme_pkg::word_t'(xs < ys);
      sme_pkg::FN_LE:  r = sme_pkg::word_t'(xs <= ys);
      sme_pkg::FN_GT:  r = sme_pkg::word_t'(xs > ys);
      sme_pkg::FN_GE:  r = sme_pkg::word_t'(xs >= ys);
      default:         r = '0;
    endcase
  end

endmodule

// File: design/sme_div.sv
// iterative signed divider, one quotient bit per cycle
// truncating quotient, remainder takes the dividend's sign; depends on sme_pkg
module sme_div (
  input  logic              clk,
  input  logic              rst_n,
  input  sme_pkg::div_req_t req,
  output sme_pkg::div_rsp_t rsp
);

  localparam int CNT_W = $clog2(sme_pkg::WORD_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(sme_pkg::WORD_W - 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  sme_pkg::word_t   rem_r, rem_nxt;
  sme_pkg::word_t   quo_r, quo_nxt;
  sme_pkg::word_t   dvs_r, dvs_nxt;
  logic             qneg_r, qneg_nxt;
  logic             rneg_r, rneg_nxt;

  logic [sme_pkg::WORD_W:0] shifted;
  logic [sme_pkg::WORD_W:0] diff;
  logic                     ge;

  // one restoring step
  assign shifted = {rem_r, quo_r[sme_pkg::WORD_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign ge      = shifted >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    qneg_nxt = qneg_r;
    rneg_nxt = rneg_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = req.dividend[sme_pkg::WORD_W-1] ? (sme_pkg::word_t'(0) - req.dividend)
                                                 : req.dividend;
      dvs_nxt  = req.divisor[sme_pkg::WORD_W-1] ? (sme_pkg::word_t'(0) - req.divisor)
                                                : req.divisor;
      qneg_nxt = req.dividend[sme_pkg::WORD_W-1] ^ req.divisor[sme_pkg::WORD_W-1];
      rneg_nxt = req.dividend[sme_pkg::WORD_W-1];
    end else if (busy_r) begin
      rem_nxt = ge ? diff[sme_pkg::WORD_W-1:0] : shifted[sme_pkg::WORD_W-1:0];
      quo_nxt = {quo_r[sme_pkg::WORD_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    dvs_r  <= dvs_nxt;
    qneg_r <= qneg_nxt;
    rneg_r <= rneg_nxt;
  end

  // sign fixup of the magnitudes
  assign rsp.done      = done_r;
  assign rsp.quotient  = qneg_r ? (sme_pkg::word_t'(0) - quo_r) : quo_r;
  assign rsp.remainder = rneg_r ? (sme_pkg::word_t'(0) - rem_r) : rem_r;

endmodule

// File: design/sme_ctrl.sv
// instruction sequencer: holds pc, bp, sp and the halt flag, steps each
// instruction through reads, checks and write-backs of the stack memory
// depends on sme_pkg; drives sme_ram, sme_alu and sme_div
module sme_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req_valid,
  input  sme_pkg::instr_t   req,
  output logic              idle,
  output logic              res_valid,
  input  logic              res_ready,
  output sme_pkg::res_t     res,
  output sme_pkg::ram_req_t ram_req,
  input  sme_pkg::word_t    ram_rd_data,
  output sme_pkg::fn_t      alu_fn,
  output sme_pkg::word_t    alu_x,
  output sme_pkg::word_t    alu_y,
  input  sme_pkg::word_t    alu_r,
  output sme_pkg::div_req_t div_req,
  input  sme_pkg::div_rsp_t div_rsp
);

  // frame layout: value, static link, dynamic link, return address
  localparam int RET_BP_OFS  = 2;
  localparam int RET_PC_OFS  = 3;
  localparam int FRAME_WORDS = 4;

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] S_CLEAR  = 4'd0;
  localparam logic [ST_W-1:0] S_IDLE   = 4'd1;
  localparam logic [ST_W-1:0] S_EXEC   = 4'd2;
  localparam logic [ST_W-1:0] S_WALK   = 4'd3;
  localparam logic [ST_W-1:0] S_WALKRD = 4'd4;
  localparam logic [ST_W-1:0] S_RET1   = 4'd5;
  localparam logic [ST_W-1:0] S_RET2   = 4'd6;
  localparam logic [ST_W-1:0] S_BIN1   = 4'd7;
  localparam logic [ST_W-1:0] S_BIN2   = 4'd8;
  localparam logic [ST_W-1:0] S_ALU    = 4'd9;
  localparam logic [ST_W-1:0] S_DIV    = 4'd10;
  localparam logic [ST_W-1:0] S_LOD    = 4'd11;
  localparam logic [ST_W-1:0] S_STO    = 4'd12;
  localparam logic [ST_W-1:0] S_POP    = 4'd13;
  localparam logic [ST_W-1:0] S_CAL    = 4'd14;
  localparam logic [ST_W-1:0] S_DONE   = 4'd15;

  logic [ST_W-1:0]              state_r, state_nxt;
  sme_pkg::addr_t               sp_r, sp_nxt;
  sme_pkg::addr_t               bp_r, bp_nxt;
  sme_pkg::pc_t                 pc_r, pc_nxt;
  logic                         halt_r, halt_nxt;
  sme_pkg::addr_t               clr_r, clr_nxt;
  sme_pkg::op_t                 op_r, op_nxt;
  logic [sme_pkg::LV_W-1:0]     lvl_r, lvl_nxt;
  sme_pkg::word_t               m_r, m_nxt;
  sme_pkg::word_t               rv_r, rv_nxt;
  sme_pkg::wide_t               b_r, b_nxt;
  sme_pkg::word_t               x_r, x_nxt;
  sme_pkg::word_t               y_r, y_nxt;
  sme_pkg::addr_t               idx_r, idx_nxt;
  logic [1:0]                   k_r, k_nxt;
  sme_pkg::res_t                res_r, res_nxt;

  sme_pkg::pc_t   npc;
  sme_pkg::wide_t sp_w, bp_w, m_w, idx_w, inc_w;
  sme_pkg::fn_t   fn;
  logic           opr_known;
  logic           unary;
  logic           fin;
  sme_pkg::res_t  fin_res;

  function automatic sme_pkg::res_t ok_res(sme_pkg::pc_t pc, logic wv, sme_pkg::word_t wval,
                                           logic h);
    sme_pkg::res_t r;
    r.next_pc     = pc;
    r.write_value = wval;
    r.write_valid = wv;
    r.halted      = h;
    r.fault       = 1'b0;
    return r;
  endfunction

  function automatic sme_pkg::res_t fault_res(sme_pkg::pc_t pc);
    sme_pkg::res_t r;
    r.next_pc     = pc;
    r.write_value = '0;
    r.write_valid = 1'b0;
    r.halted      = 1'b0;
    r.fault       = 1'b1;
    return r;
  endfunction

  // decoded helpers
  assign npc       = pc_r + 1'b1;
  assign sp_w      = sme_pkg::ext_addr(sp_r);
  assign bp_w      = sme_pkg::ext_addr(bp_r);
  assign m_w       = sme_pkg::ext_word(m_r);
  assign idx_w     = b_r + m_w;
  assign inc_w     = sp_w + m_w;
  assign fn        = m_r[sme_pkg::FN_W-1:0];
  assign opr_known = !m_r[sme_pkg::WORD_W-1] && (m_r <= sme_pkg::word_t'(sme_pkg::FN_GE));
  assign unary     = (fn == sme_pkg::FN_NEG) || (fn == sme_pkg::FN_ODD);

  // alu operands
  assign alu_fn = fn;
  assign alu_x  = x_r;
  assign alu_y  = y_r;

  assign idle = (state_r == S_IDLE);

  // sequencer
  always_comb begin
    state_nxt        = state_r;
    sp_nxt           = sp_r;
    bp_nxt           = bp_r;
    pc_nxt           = pc_r;
    halt_nxt         = halt_r;
    clr_nxt          = clr_r;
    op_nxt           = op_r;
    lvl_nxt          = lvl_r;
    m_nxt            = m_r;
    rv_nxt           = rv_r;
    b_nxt            = b_r;
    x_nxt            = x_r;
    y_nxt            = y_r;
    idx_nxt          = idx_r;
    k_nxt            = k_r;
    res_nxt          = res_r;
    ram_req          = '0;
    div_req.start    = 1'b0;
    div_req.dividend = x_r;
    div_req.divisor  = y_r;
    fin              = 1'b0;
    fin_res          = fault_res(pc_r);

    unique case (state_r)
      // zero the stack memory after reset
      S_CLEAR: begin
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = clr_r;
        ram_req.wr_data = '0;
        clr_nxt         = clr_r + 1'b1;
        if (clr_r == sme_pkg::ADDR_MAX) begin
          state_nxt = S_IDLE;
        end
      end

      // take a request
      S_IDLE: begin
        if (req_valid) begin
          op_nxt = req.opcode_field;
          m_nxt  = req.operand;
          rv_nxt = req.read_value;
          b_nxt  = bp_w;
          if (int'(req.level) > sme_pkg::MAX_LEVELS) begin
            lvl_nxt = sme_pkg::LV_W'(sme_pkg::MAX_LEVELS);
          end else begin
            lvl_nxt = sme_pkg::LV_W'(req.level);
          end
          state_nxt = S_EXEC;
        end
      end

      // first step of every instruction
      S_EXEC: begin
        if (halt_r) begin
          fin     = 1'b1;
          fin_res = ok_res(pc_r, 1'b0, '0, 1'b1);
        end else begin
          unique case (op_r)
            sme_pkg::OP_LIT, sme_pkg::OP_READ: begin
              fin = 1'b1;
              if (sp_r != sme_pkg::ADDR_MAX) begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = sp_r + 1'b1;
                ram_req.wr_data = (op_r == sme_pkg::OP_LIT) ? m_r : rv_r;
                sp_nxt          = sp_r + 1'b1;
                pc_nxt          = npc;
                fin_res         = ok_res(npc, 1'b0, '0, 1'b0);
              end
            end
            sme_pkg::OP_OPR: begin
              if (!opr_known) begin
                fin     = 1'b1;
                pc_nxt  = npc;
                fin_res = ok_res(npc, 1'b0, '0, 1'b0);
              end else if (fn == sme_pkg::FN_RET) begin
                if (bp_r == sme_pkg::addr_t'(1)) begin
                  // return from the outermost frame halts
                  fin      = 1'b1;
                  sp_nxt   = '0;
                  bp_nxt   = '0;
                  pc_nxt   = '0;
                  halt_nxt = 1'b1;
                  fin_res  = ok_res('0, 1'b0, '0, 1'b1);
                end else if (bp_r == '0 ||
                             !sme_pkg::in_stack(bp_w + sme_pkg::wide_t'(RET_PC_OFS))) begin
                  fin = 1'b1;
                end else begin
                  ram_req.rd_en   = 1'b1;
                  ram_req.rd_addr = bp_r + sme_pkg::addr_t'(RET_BP_OFS);
                  state_nxt       = S_RET1;
                end
              end else if (unary) begin
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = sp_r;
                state_nxt       = S_BIN2;
              end else if (sp_r == '0) begin
                fin = 1'b1;
              end else begin
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = sp_r - 1'b1;
                state_nxt       = S_BIN1;
              end
            end
            sme_pkg::OP_LOD, sme_pkg::OP_STO, sme_pkg::OP_CAL: begin
              state_nxt = S_WALK;
            end
            sme_pkg::OP_INC: begin
              fin = 1'b1;
              if (sme_pkg::in_stack(inc_w)) begin
                sp_nxt  = inc_w[sme_pkg::ADDR_W-1:0];
                pc_nxt  = npc;
                fin_res = ok_res(npc, 1'b0, '0, 1'b0);
              end
            end
            sme_pkg::OP_JMP: begin
              fin     = 1'b1;
              pc_nxt  = m_r[sme_pkg::PC_W-1:0];
              fin_res = ok_res(m_r[sme_pkg::PC_W-1:0], 1'b0, '0, 1'b0);
            end
            sme_pkg::OP_JPC, sme_pkg::OP_WRITE: begin
              if (sp_r == '0) begin
                fin = 1'b1;
              end else begin
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = sp_r;
                state_nxt       = S_POP;
              end
            end
            sme_pkg::OP_HALT: begin
              fin      = 1'b1;
              halt_nxt = 1'b1;
              pc_nxt   = npc;
              fin_res  = ok_res(npc, 1'b0, '0, 1'b1);
            end
            default: begin
              fin     = 1'b1;
              pc_nxt  = npc;
              fin_res = ok_res(npc, 1'b0, '0, 1'b0);
            end
          endcase
        end
      end

      // static link walk, then the address checks of lod, sto and cal
      S_WALK: begin
        if (lvl_r != '0) begin
          if (sme_pkg::in_stack(b_r) && sme_pkg::in_stack(b_r + sme_pkg::wide_t'(1))) begin
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = b_r[sme_pkg::ADDR_W-1:0] + 1'b1;
            state_nxt       = S_WALKRD;
          end else begin
            fin = 1'b1;
          end
        end else if (!sme_pkg::in_stack(b_r)) begin
          fin = 1'b1;
        end else begin
          unique case (op_r)
            sme_pkg::OP_LOD: begin
              if (sme_pkg::in_stack(idx_w) && sp_r != sme_pkg::ADDR_MAX) begin
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = idx_w[sme_pkg::ADDR_W-1:0];
                state_nxt       = S_LOD;
              end else begin
                fin = 1'b1;
              end
            end
            sme_pkg::OP_STO: begin
              if (sme_pkg::in_stack(idx_w) && sp_r != '0) begin
                idx_nxt         = idx_w[sme_pkg::ADDR_W-1:0];
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = sp_r;
                state_nxt       = S_STO;
              end else begin
                fin = 1'b1;
              end
            end
            default: begin
              if (sme_pkg::in_stack(sp_w + sme_pkg::wide_t'(FRAME_WORDS))) begin
                k_nxt     = '0;
                state_nxt = S_CAL;
              end else begin
                fin = 1'b1;
              end
            end
          endcase
        end
      end

      S_WALKRD: begin
        b_nxt     = sme_pkg::ext_word(ram_rd_data);
        lvl_nxt   = lvl_r - 1'b1;
        state_nxt = S_WALK;
      end

      // return: new bp read, then return address
      S_RET1: begin
        if (sme_pkg::in_stack(sme_pkg::ext_word(ram_rd_data))) begin
          x_nxt           = ram_rd_data;
          ram_req.rd_en   = 1'b1;
          ram_req.rd_addr = bp_r + sme_pkg::addr_t'(RET_PC_OFS);
          state_nxt       = S_RET2;
        end else begin
          fin = 1'b1;
        end
      end

      S_RET2: begin
        fin     = 1'b1;
        sp_nxt  = bp_r - 1'b1;
        bp_nxt  = x_r[sme_pkg::ADDR_W-1:0];
        pc_nxt  = ram_rd_data[sme_pkg::PC_W-1:0];
        fin_res = ok_res(ram_rd_data[sme_pkg::PC_W-1:0], 1'b0, '0, 1'b0);
      end

      // operand fetch for opr
      S_BIN1: begin
        x_nxt           = ram_rd_data;
        ram_req.rd_en   = 1'b1;
        ram_req.rd_addr = sp_r;
        state_nxt       = S_BIN2;
      end

      S_BIN2: begin
        y_nxt     = ram_rd_data;
        state_nxt = S_ALU;
      end

      // compute and write back, or hand off to the divider
      S_ALU: begin
        if (fn == sme_pkg::FN_DIV || fn == sme_pkg::FN_MOD) begin
          if (y_r == '0) begin
            fin = 1'b1;
          end else begin
            div_req.start = 1'b1;
            state_nxt     = S_DIV;
          end
        end else begin
          fin             = 1'b1;
          ram_req.wr_en   = 1'b1;
          ram_req.wr_data = alu_r;
          if (unary) begin
            ram_req.wr_addr = sp_r;
          end else begin
            ram_req.wr_addr = sp_r - 1'b1;
            sp_nxt          = sp_r - 1'b1;
          end
          pc_nxt  = npc;
          fin_res = ok_res(npc, 1'b0, '0, 1'b0);
        end
      end

      S_DIV: begin
        if (div_rsp.done) begin
          fin             = 1'b1;
          ram_req.wr_en   = 1'b1;
          ram_req.wr_addr = sp_r - 1'b1;
          ram_req.wr_data = (fn == sme_pkg::FN_DIV) ? div_rsp.quotient : div_rsp.remainder;
          sp_nxt          = sp_r - 1'b1;
          pc_nxt          = npc;
          fin_res         = ok_res(npc, 1'b0, '0, 1'b0);
        end
      end

      // push the loaded word
      S_LOD: begin
        fin             = 1'b1;
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = sp_r + 1'b1;
        ram_req.wr_data = ram_rd_data;
        sp_nxt          = sp_r + 1'b1;
        pc_nxt          = npc;
        fin_res         = ok_res(npc, 1'b0, '0, 1'b0);
      end

      // store the popped word
      S_STO: begin
        fin             = 1'b1;
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = idx_r;
        ram_req.wr_data = ram_rd_data;
        sp_nxt          = sp_r - 1'b1;
        pc_nxt          = npc;
        fin_res         = ok_res(npc, 1'b0, '0, 1'b0);
      end

      // conditional jump or output of the top word
      S_POP: begin
        fin    = 1'b1;
        sp_nxt = sp_r - 1'b1;
        if (op_r == sme_pkg::OP_JPC) begin
          if (ram_rd_data == '0) begin
            pc_nxt  = m_r[sme_pkg::PC_W-1:0];
            fin_res = ok_res(m_r[sme_pkg::PC_W-1:0], 1'b0, '0, 1'b0);
          end else begin
            pc_nxt  = npc;
            fin_res = ok_res(npc, 1'b0, '0, 1'b0);
          end
        end else begin
          pc_nxt  = npc;
          fin_res = ok_res(npc, 1'b1, ram_rd_data, 1'b0);
        end
      end

      // build the new frame, one word a cycle
      S_CAL: begin
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = sp_r + sme_pkg::addr_t'(k_r) + 1'b1;
        unique case (k_r)
          2'd0: ram_req.wr_data = '0;
          2'd1: ram_req.wr_data = b_r[sme_pkg::WORD_W-1:0];
          2'd2: ram_req.wr_data = sme_pkg::word_t'(bp_r);
          2'd3: ram_req.wr_data = sme_pkg::word_t'(npc);
        endcase
        k_nxt = k_r + 1'b1;
        if (k_r == 2'd3) begin
          fin     = 1'b1;
          bp_nxt  = sp_r + 1'b1;
          pc_nxt  = m_r[sme_pkg::PC_W-1:0];
          fin_res = ok_res(m_r[sme_pkg::PC_W-1:0], 1'b0, '0, 1'b0);
        end
      end

      // result waits for the output register
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (fin) begin
      res_nxt   = fin_res;
      state_nxt = res_ready ? S_IDLE : S_DONE;
    end
  end

  // result handoff
  assign res_valid = fin || (state_r == S_DONE);
  assign res       = (state_r == S_DONE) ? res_r : fin_res;

  // machine registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      sp_r    <= '0;
      bp_r    <= sme_pkg::addr_t'(1);
      pc_r    <= '0;
      halt_r  <= 1'b0;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      sp_r    <= sp_nxt;
      bp_r    <= bp_nxt;
      pc_r    <= pc_nxt;
      halt_r  <= halt_nxt;
      clr_r   <= clr_nxt;
    end
  end

  // per-instruction working registers
  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    lvl_r <= lvl_nxt;
    m_r   <= m_nxt;
    rv_r  <= rv_nxt;
    b_r   <= b_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    idx_r <= idx_nxt;
    k_r   <= k_nxt;
    res_r <= res_nxt;
  end

endmodule

// File: design/stack_machine_execute.sv
// divide and modulo use a 32-step divider; lod, sto and cal first walk the static
// links, one level at a time. a fault answers once its check fails.
// throughput: one request at a time, the next is taken the cycle after the result
// enters the output register.
// reset: synchronous, active low; the 2048-word stack is then zeroed.
module stack_machine_execute (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [3:0]          in_opcode_field,
  input  logic [1:0]          in_level,
  input  logic signed [31:0]  in_operand,
  input  logic signed [31:0]  in_read_value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [8:0]          out_next_pc,
  output logic signed [31:0]  out_write_value,
  output logic                out_write_valid,
  output logic                out_halted,
  output logic                out_fault
);

  sme_pkg::instr_t   req;
  logic              idle;
  logic              res_valid;
  logic              res_ready;
  sme_pkg::res_t     res;
  sme_pkg::ram_req_t ram_req;
  sme_pkg::word_t    ram_rd_data;
  sme_pkg::fn_t      alu_fn;
  sme_pkg::word_t    alu_x, alu_y, alu_r;
  sme_pkg::div_req_t div_req;
  sme_pkg::div_rsp_t div_rsp;

  logic              out_valid_r;
  sme_pkg::res_t     out_res_r;

  // request packing
  assign req.opcode_field = in_opcode_field;
  assign req.level        = in_level;
  assign req.operand      = sme_pkg::word_t'(in_operand);
  assign req.read_value   = sme_pkg::word_t'(in_read_value);
  assign in_stall         = !idle;

  sme_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (in_valid),
    .req         (req),
    .idle        (idle),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .ram_req     (ram_req),
    .ram_rd_data (ram_rd_data),
    .alu_fn      (alu_fn),
    .alu_x       (alu_x),
    .alu_y       (alu_y),
    .alu_r       (alu_r),
    .div_req     (div_req),
    .div_rsp     (div_rsp)
  );

  sme_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (ram_rd_data)
  );

  sme_alu u_alu (
    .fn (alu_fn),
    .x  (alu_x),
    .y  (alu_y),
    .r  (alu_r)
  );

  sme_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // output register, loads whenever it is empty or being drained
  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_next_pc     = out_res_r.next_pc;
  assign out_write_value = $signed(out_res_r.write_value);
  assign out_write_valid = out_res_r.write_valid;
  assign out_halted      = out_res_r.halted;
  assign out_fault       = out_res_r.fault;

endmodule

// File: design/sme_checker.sv
// port-level checks of the stack machine execute block, bound to the top level
// depends on nothing but the top level's ports
module sme_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [8:0]         out_next_pc,
  input logic signed [31:0] out_write_value,
  input logic               out_write_valid,
  input logic               out_halted,
  input logic               out_fault
);

  logic       in_acc, out_acc;
  logic [2:0] pend_r, pend_nxt;
  logic       halt_seen_r, halt_seen_nxt;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // requests taken but not yet delivered, and sticky halt
  always_comb begin
    pend_nxt      = pend_r + 3'(in_acc) - 3'(out_acc);
    halt_seen_nxt = halt_seen_r || (out_acc && out_halted);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      halt_seen_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      halt_seen_r <= halt_seen_nxt;
    end
  end

  // one request in flight inside the block at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("request taken while the previous one is still executing");

  // every result belongs to an earlier request
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pend_r != 3'd0) && (pend_r <= 3'd2))
    else $error("result without a matching request");

  // a halted machine answers halted and nothing else
  a_after_halt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && halt_seen_r) |-> (out_halted && !out_fault && !out_write_valid
                                    && out_write_value == 32'sd0))
    else $error("machine left the halted state");

  // a faulting step reports nothing else
  a_fault_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_fault) |-> (!out_write_valid && !out_halted))
    else $error("fault combined with output or halt");

  // held result stays valid, with next pc and fault stable, while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_next_pc)
                                  && $stable(out_fault)))
    else $error("stalled result changed");

endmodule

bind stack_machine_execute sme_checker u_sme_checker (.*);

// File: tb/sme_result_checker.sv
// result checker for the stack machine execute block
// watches both channels, predicts each result from its own machine state and compares
// depends on sme_pkg
module sme_result_checker
  import sme_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [3:0]         in_opcode_field,
  input  logic [1:0]         in_level,
  input  logic signed [31:0] in_operand,
  input  logic signed [31:0] in_read_value,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [8:0]         out_next_pc,
  input  logic signed [31:0] out_write_value,
  input  logic               out_write_valid,
  input  logic               out_halted,
  input  logic               out_fault,
  output int                 mismatches,
  output int                 pending_results,
  output int                 stack_top,
  output int                 frame_base
);

  // machine state as the block should hold it
  word_t  stack_mem [STACK_DEPTH];
  longint sp_r;
  longint bp_r;
  pc_t    pc_r;
  logic   halt_r;

  res_t predicted_results[$];
  res_t want;
  int   results_seen;

  initial begin
    mismatches      = 0;
    pending_results = 0;
    stack_top       = 0;
    frame_base      = 1;
    results_seen    = 0;
  end

  function automatic bit in_range(longint i);
    return (i >= 0) && (i < STACK_DEPTH);
  endfunction

  // follow static links down lv levels, -1 when any index leaves the stack
  function automatic longint link_base(logic [1:0] lv, longint base);
    longint b;
    int     n;
    int     depth;
    b = base;
    depth = (lv > MAX_LEVELS) ? MAX_LEVELS : lv;
    for (n = 0; n < depth; n++) begin
      if (!in_range(b) || !in_range(b + 1)) return -1;
      b = longint'($signed(stack_mem[b + 1]));
    end
    return in_range(b) ? b : -1;
  endfunction

  // execute one instruction on the predicted state and return its result
  function automatic res_t exec_instr(op_t op, logic [1:0] lv, word_t opnd, word_t rdv);
    longint sp;
    longint bp;
    longint b;
    longint idx;
    longint m;
    pc_t    pc;
    word_t  x;
    word_t  y;
    word_t  r;
    word_t  wval;
    logic   halt;
    logic   flt;
    logic   wv;
    fn_t    fn;
    int     nw;
    int     k;
    longint widx [4];
    word_t  wdat [4];
    res_t   res;

    res = '0;
    if (halt_r) begin
      res.next_pc = pc_r;
      res.halted  = 1'b1;
      return res;
    end
    sp   = sp_r;
    bp   = bp_r;
    pc   = pc_r + 1'b1;
    m    = longint'($signed(opnd));
    halt = 1'b0;
    flt  = 1'b0;
    wv   = 1'b0;
    wval = '0;
    nw   = 0;
    b    = 0;
    r    = '0;

    case (op)
      OP_LIT, OP_READ: begin
        if (!in_range(sp + 1)) flt = 1'b1;
        else begin
          sp++;
          widx[0] = sp;
          wdat[0] = (op == OP_LIT) ? opnd : rdv;
          nw = 1;
        end
      end
      OP_OPR: begin
        // functions outside the known range only advance the pc
        if (m >= 0 && m <= longint'(FN_GE)) begin
          fn = fn_t'(m);
          case (fn)
            FN_RET: begin
              if (bp == 1) begin
                // return from the outermost frame stops the machine
                sp   = 0;
                bp   = 0;
                pc   = '0;
                halt = 1'b1;
              end else if (!in_range(bp - 1) || !in_range(bp + 3)) flt = 1'b1;
              else begin
                idx = longint'($signed(stack_mem[bp + 2]));
                if (!in_range(idx)) flt = 1'b1;
                else begin
                  pc = pc_t'(stack_mem[bp + 3]);
                  sp = bp - 1;
                  bp = idx;
                end
              end
            end
            FN_NEG, FN_ODD: begin
              if (!in_range(sp)) flt = 1'b1;
              else begin
                x = stack_mem[sp];
                widx[0] = sp;
                wdat[0] = (fn == FN_NEG) ? -x : {31'b0, x[0]};
                nw = 1;
              end
            end
            default: begin
              if (!in_range(sp) || !in_range(sp - 1)) flt = 1'b1;
              else begin
                x = stack_mem[sp - 1];
                y = stack_mem[sp];
                case (fn)
                  FN_ADD: r = x + y;
                  FN_SUB: r = x - y;
                  FN_MUL: r = x * y;
                  FN_DIV, FN_MOD: begin
                    // divide by minus one wraps, its remainder is zero
                    if (y == '0) flt = 1'b1;
                    else if (y == '1) r = (fn == FN_DIV) ? -x : '0;
                    else if (fn == FN_DIV) r = word_t'($signed(x) / $signed(y));
                    else r = word_t'($signed(x) % $signed(y));
                  end
                  FN_EQ: r = word_t'($signed(x) == $signed(y));
                  FN_NE: r = word_t'($signed(x) != $signed(y));
                  FN_LT: r = word_t'($signed(x) < $signed(y));
                  FN_LE: r = word_t'($signed(x) <= $signed(y));
                  FN_GT: r = word_t'($signed(x) > $signed(y));
                  default: r = word_t'($signed(x) >= $signed(y));
                endcase
                if (!flt) begin
                  sp--;
                  widx[0] = sp;
                  wdat[0] = r;
                  nw = 1;
                end
              end
            end
          endcase
        end
      end
      OP_LOD: begin
        b = link_base(lv, bp);
        idx = b + m;
        if (b < 0 || !in_range(idx) || !in_range(sp + 1)) flt = 1'b1;
        else begin
          sp++;
          widx[0] = sp;
          wdat[0] = stack_mem[idx];
          nw = 1;
        end
      end
      OP_STO: begin
        b = link_base(lv, bp);
        idx = b + m;
        if (b < 0 || !in_range(idx) || !in_range(sp) || !in_range(sp - 1)) flt = 1'b1;
        else begin
          widx[0] = idx;
          wdat[0] = stack_mem[sp];
          nw = 1;
          sp--;
        end
      end
      OP_CAL: begin
        b = link_base(lv, bp);
        if (b < 0 || !in_range(sp + 1) || !in_range(sp + 4)) flt = 1'b1;
        else begin
          // new frame: function value, static link, dynamic link, return address
          widx[0] = sp + 1; wdat[0] = '0;
          widx[1] = sp + 2; wdat[1] = word_t'(b);
          widx[2] = sp + 3; wdat[2] = word_t'(bp);
          widx[3] = sp + 4; wdat[3] = word_t'(pc);
          nw = 4;
          bp = sp + 1;
          pc = pc_t'(opnd);
        end
      end
      OP_INC: begin
        if (!in_range(sp + m)) flt = 1'b1;
        else sp = sp + m;
      end
      OP_JMP: pc = pc_t'(opnd);
      OP_JPC, OP_WRITE: begin
        if (!in_range(sp) || !in_range(sp - 1)) flt = 1'b1;
        else begin
          if (op == OP_JPC) begin
            if (stack_mem[sp] == '0) pc = pc_t'(opnd);
          end else begin
            wv   = 1'b1;
            wval = stack_mem[sp];
          end
          sp--;
        end
      end
      OP_HALT: halt = 1'b1;
      default: ;
    endcase

    // a fault leaves every register and stack word untouched
    if (flt) begin
      res.next_pc = pc_r;
      res.fault   = 1'b1;
      return res;
    end
    for (k = 0; k < nw; k++) stack_mem[widx[k]] = wdat[k];
    sp_r   = sp;
    bp_r   = bp;
    pc_r   = pc;
    halt_r = halt;
    res.next_pc     = pc;
    res.write_value = wv ? wval : '0;
    res.write_valid = wv;
    res.halted      = halt;
    return res;
  endfunction

  task automatic clear_model();
    int i;
    for (i = 0; i < STACK_DEPTH; i++) stack_mem[i] = '0;
    sp_r   = 0;
    bp_r   = 1;
    pc_r   = '0;
    halt_r = 1'b0;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] exp_val);
    if (got !== exp_val) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch in %s of result %0d: expected %h, got %h",
                 name, results_seen, exp_val, got);
    end
  endtask

  // compare each accepted result first, then predict the accepted request
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_model();
      predicted_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (predicted_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d arrived with no request outstanding", results_seen);
        end else begin
          want = predicted_results.pop_front();
          check_field("next_pc", 32'(out_next_pc), 32'(want.next_pc));
          check_field("write_value", out_write_value, want.write_value);
          check_field("write_valid", 32'(out_write_valid), 32'(want.write_valid));
          check_field("halted", 32'(out_halted), 32'(want.halted));
          check_field("fault", 32'(out_fault), 32'(want.fault));
        end
      end
      if (in_valid && !in_stall)
        predicted_results.push_back(exec_instr(in_opcode_field, in_level,
                                               in_operand, in_read_value));
    end
    pending_results = predicted_results.size();
    stack_top       = int'(sp_r);
    frame_base      = int'(bp_r);
  end

endmodule

// File: tb/tb_stack_machine_execute.sv
// testbench top for the stack machine execute block
// drives instruction requests and result stalls, gives the verdict from the checker
// depends on sme_pkg, stack_machine_execute and sme_result_checker
module tb_stack_machine_execute;
  import sme_pkg::*;

  localparam int    ITEMS          = 750;
  localparam int    LONG_HOLD      = 400;
  localparam int    WATCHDOG_LIMIT = 8000;
  localparam op_t   OP_NONE        = 4'd0;
  localparam op_t   OP_UNUSED      = 4'd15;
  localparam word_t FN_UNUSED      = 32'd14;
  localparam word_t INT_MIN        = 32'h8000_0000;
  localparam word_t INT_MAX        = 32'h7FFF_FFFF;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid;
  logic               in_stall;
  logic [3:0]         in_opcode_field;
  logic [1:0]         in_level;
  logic signed [31:0] in_operand;
  logic signed [31:0] in_read_value;
  logic               out_valid;
  logic               out_stall;
  logic [8:0]         out_next_pc;
  logic signed [31:0] out_write_value;
  logic               out_write_valid;
  logic               out_halted;
  logic               out_fault;

  int mismatches;
  int pending_results;
  int stack_top;
  int frame_base;
  int sent;
  int burst_left;
  int idle_cycles;
  bit hold_req;
  bit hold_done;

  stack_machine_execute dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode_field (in_opcode_field),
    .in_level        (in_level),
    .in_operand      (in_operand),
    .in_read_value   (in_read_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_next_pc     (out_next_pc),
    .out_write_value (out_write_value),
    .out_write_valid (out_write_valid),
    .out_halted      (out_halted),
    .out_fault       (out_fault)
  );

  sme_result_checker result_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode_field (in_opcode_field),
    .in_level        (in_level),
    .in_operand      (in_operand),
    .in_read_value   (in_read_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_next_pc     (out_next_pc),
    .out_write_value (out_write_value),
    .out_write_valid (out_write_valid),
    .out_halted      (out_halted),
    .out_fault       (out_fault),
    .mismatches      (mismatches),
    .pending_results (pending_results),
    .stack_top       (stack_top),
    .frame_base      (frame_base)
  );

  // clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // watchdog on cycles with no request and no result accepted
  initial idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  function automatic instr_t instr(op_t op, logic [1:0] lv, word_t opnd, word_t rdv);
    instr_t it;
    it.opcode_field = op;
    it.level        = lv;
    it.operand      = opnd;
    it.read_value   = rdv;
    return it;
  endfunction

  // data words biased toward the edges of the range
  function automatic word_t pick_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return INT_MIN;
      3: return INT_MAX;
      4, 5: return word_t'($urandom_range(0, 20));
      6: return word_t'(-int'($urandom_range(1, 9)));
      default: return $urandom();
    endcase
  endfunction

  // frame offsets, mostly inside the current frame
  function automatic word_t pick_offset();
    case ($urandom_range(0, 7))
      6: return word_t'(-int'($urandom_range(1, 4)));
      7: return pick_word();
      default: return word_t'($urandom_range(0, 7));
    endcase
  endfunction

  // keep the machine running: no halt, no return from the outermost frame
  function automatic instr_t keep_running(instr_t it);
    if (it.opcode_field == OP_HALT) it.opcode_field = OP_UNUSED;
    if (it.opcode_field == OP_OPR && it.operand == word_t'(FN_RET) && frame_base == 1)
      it.operand = word_t'(FN_ADD);
    return it;
  endfunction

  function automatic instr_t make_instr();
    instr_t it;
    int     sel;
    sel = $urandom_range(0, 99);
    it = instr(OP_LIT, 2'($urandom_range(0, 3)), pick_word(), $urandom());
    if (sel < 14) it.opcode_field = OP_LIT;
    else if (sel < 19) it.opcode_field = OP_READ;
    else if (sel < 44) begin
      it.opcode_field = OP_OPR;
      it.operand = ($urandom_range(0, 9) == 0) ? pick_word()
                 : word_t'($urandom_range(FN_NEG, FN_GE));
    end else if (sel < 52) begin
      it.opcode_field = OP_LOD;
      it.operand = pick_offset();
    end else if (sel < 58) begin
      it.opcode_field = OP_STO;
      it.operand = pick_offset();
    end else if (sel < 62) begin
      it.opcode_field = OP_CAL;
      it.operand = $urandom();
    end else if (sel < 69) begin
      it.opcode_field = OP_INC;
      it.operand = ($urandom_range(0, 7) == 0) ? pick_word()
                 : word_t'(int'($urandom_range(0, 8)) - 3);
    end else if (sel < 73) begin
      it.opcode_field = OP_JMP;
      it.operand = $urandom();
    end else if (sel < 78) begin
      it.opcode_field = OP_JPC;
      it.operand = $urandom();
    end else if (sel < 86) it.opcode_field = OP_WRITE;
    else if (sel < 91) begin
      it.opcode_field = OP_OPR;
      it.operand = word_t'(FN_RET);
    end else begin
      // noise: any code with raw fields
      it.opcode_field = op_t'($urandom_range(0, 15));
      it.operand = $urandom();
    end
    // keep the stack from running away
    if (stack_top > 48 && (it.opcode_field == OP_LIT || it.opcode_field == OP_READ))
      it.opcode_field = OP_WRITE;
    return keep_running(it);
  endfunction

  // send one request in bursts with random gaps, return once it is taken
  task automatic issue(instr_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid        <= 1'b1;
    in_opcode_field <= it.opcode_field;
    in_level        <= it.level;
    in_operand      <= it.operand;
    in_read_value   <= it.read_value;
    sent++;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // result side stalls on its own pattern, with one long hold
  initial begin : receiver
    int mode;
    int span;
    int k;
    out_stall = 1'b0;
    k = 0;
    @(posedge rst_n);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        out_stall <= 1'b0;
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 80);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 1) == 0);
          default: out_stall <= (k % 4 != 0);
        endcase
        k++;
      end
    end
  end

  initial begin : stimulus
    int lv;
    in_valid        = 1'b0;
    in_opcode_field = '0;
    in_level        = '0;
    in_operand      = '0;
    in_read_value   = '0;
    sent            = 0;
    burst_left      = 0;
    hold_req        = 1'b0;
    hold_done       = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: overflowing divide, divide by zero, signed compare and modulo
    issue(instr(OP_LIT, 2'd0, INT_MIN, '0));
    issue(instr(OP_READ, 2'd0, '0, '1));
    issue(instr(OP_OPR, 2'd0, word_t'(FN_DIV), '0));
    issue(instr(OP_LIT, 2'd0, '0, '1));
    issue(instr(OP_OPR, 2'd0, word_t'(FN_MOD), '0));
    issue(instr(OP_OPR, 2'd0, word_t'(FN_LT), '0));
    issue(instr(OP_OPR, 2'd0, word_t'(FN_NEG), '0));
    issue(instr(OP_LIT, 2'd0, 32'd7, '0));
    issue(instr(OP_OPR, 2'd0, word_t'(FN_MOD), '0));
    // frames, static link walk that leaves the stack, code address wrap
    issue(instr(OP_INC, 2'd0, 32'd3, '0));
    issue(instr(OP_STO, 2'd0, 32'd2, '0));
    issue(instr(OP_LOD, 2'd3, '0, '0));
    issue(instr(OP_CAL, 2'd1, 32'hFFFF_FE05, '0));
    issue(instr(OP_INC, 2'd0, 32'd4, '0));
    issue(instr(OP_LOD, 2'd0, '1, '0));
    issue(instr(OP_JMP, 2'd0, '1, '0));
    issue(instr(OP_LIT, 2'd0, '0, '0));
    issue(instr(OP_JPC, 2'd0, 32'd100, '0));
    issue(instr(OP_LIT, 2'd0, 32'd5, '0));
    issue(instr(OP_WRITE, 2'd0, '0, '0));
    // unknown codes, out of range increment, return to the caller
    issue(instr(OP_NONE, 2'd2, '1, '1));
    issue(instr(OP_UNUSED, 2'd1, INT_MAX, INT_MIN));
    issue(instr(OP_OPR, 2'd0, FN_UNUSED, '0));
    issue(instr(OP_INC, 2'd0, INT_MAX, '0));
    issue(keep_running(instr(OP_OPR, 2'd0, word_t'(FN_RET), '0)));

    // random programs, sometimes wrapped in a called frame
    hold_req = 1'b1;
    while (sent < ITEMS - 6) begin
      if ($urandom_range(0, 4) == 0) begin
        lv = $urandom_range(0, 3);
        issue(instr(OP_CAL, 2'(lv), $urandom(), $urandom()));
        issue(instr(OP_INC, 2'd0, word_t'(4 + $urandom_range(0, 3)), $urandom()));
        repeat ($urandom_range(2, 8)) issue(make_instr());
        issue(keep_running(instr(OP_OPR, 2'(lv), word_t'(FN_RET), $urandom())));
      end else issue(make_instr());
    end

    // stop the machine, then requests that must all be answered as halted
    if (frame_base == 1 && $urandom_range(0, 1) == 1)
      issue(instr(OP_OPR, 2'd0, word_t'(FN_RET), $urandom()));
    else issue(instr(OP_HALT, 2'($urandom_range(0, 3)), $urandom(), $urandom()));
    repeat (5) issue(make_instr());
    in_valid <= 1'b0;

    while (pending_results != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
